// ===== hdl/nwg_pkg.sv =====
package nwg_pkg;

   // Width of the shift register and of one noise word
   localparam int WordBits = 16;
   localparam int CountBits = $clog2(WordBits);

   // Feedback polynomial after reset
   localparam logic [WordBits-1:0] PolyReset = WordBits'(16'h8005);

   // Shift register contents after reset
   localparam logic [WordBits-1:0] SeedReset = WordBits'(1);

   // Request kinds carried in tuser
   localparam logic ReqTick = 1'b0;
   localparam logic ReqSeed = 1'b1;

   // Configuration register indexes
   localparam logic CsrPoly = 1'b0;
   localparam logic CsrIncr = 1'b1;

   // Per-cycle control shared by every cell of the chain
   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

endpackage

// ===== hdl/nwg_cell.sv =====
module nwg_cell
   import nwg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          reset_bit,
   input  logic          load_bit,
   input  logic          carry_in,
   output logic          carry_out,
   input  logic          shift_in,
   input  logic          tap,
   output logic          pre_bit
);

   logic bit_ff;
   logic bit_in;

   // Apply the increment carry ahead of the shift
   always_comb begin
      pre_bit   = bit_ff ^ carry_in;
      carry_out = bit_ff & carry_in;
   end

   // Load a seed bit, or take the neighbor's bit with the feedback tap
   always_comb begin
      bit_in = bit_ff;
      if (ctrl.load) begin
         bit_in = load_bit;
      end else if (ctrl.step) begin
         bit_in = shift_in ^ tap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= reset_bit;
      end else begin
         bit_ff <= bit_in;
      end
   end

endmodule

// ===== hdl/lfsr_noise_word_generator_unit.sv =====
// Galois LFSR noise word generator.
// Request channel (req_*): tuser selects the kind of item, 0 = tick, 1 = seed load;
// tdata carries the seed. A seed load overwrites the shift register and gives
// no result. A tick optionally increments the register, then clocks it through
// sixteen shift steps, one step per cycle unless stalled, in a chain of one-bit
// cells; the bits leaving the top form the noise word, first bit in the MSB.
// Result channel (rsp_*): one 16-bit noise word per tick, held in an output
// register, so the next item is taken while a word waits to be read.
// A new item is taken only while the chain is idle, not during a tick's steps;
// a seed load leaves the chain idle.
// Configuration (csr_*): index 0 is the feedback polynomial, index 1 the
// increment enable; csr_ready is always high, writes belong to idle periods.
// Reset: the register returns to 1, the polynomial to 0x8005, increment off.
// A stalled receiver holds the output word; a finished tick then waits in the
// chain, and no new item is taken until the word can move to the output.
module lfsr_noise_word_generator_unit
   import nwg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [WordBits-1:0] req_tdata,   // [15:0] seed_value
   input  logic                req_tuser,   // [0] req_type
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WordBits-1:0] rsp_tdata,   // [15:0] noise_word
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [WordBits-1:0] csr_data
);

   logic [WordBits-1:0]  poly_ff;
   logic                 incr_ff;
   logic                 busy_ff;
   logic                 busy_in;
   logic [CountBits-1:0] cnt_ff;
   logic [CountBits-1:0] cnt_in;
   logic [WordBits-1:0]  word_ff;
   logic [WordBits-1:0]  word_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [WordBits-1:0]  rsp_data_ff;
   logic [WordBits-1:0]  rsp_data_in;

   logic                 req_fire;
   logic                 tick_fire;
   logic                 seed_fire;
   logic                 last_step;
   logic                 out_free;
   logic                 finish;
   logic                 top_bit;
   cell_ctrl_type        ctrl;
   logic [WordBits-1:0]  pre;
   logic [WordBits-1:0]  carry;

   // Handshake decode
   always_comb begin
      req_fire   = req_tvalid & req_tready;
      tick_fire  = req_fire & (req_tuser == ReqTick);
      seed_fire  = req_fire & (req_tuser == ReqSeed);
      last_step  = busy_ff & (cnt_ff == CountBits'(WordBits - 1));
      out_free   = ~rsp_valid_ff | rsp_tready;
      finish     = last_step & out_free;
      req_tready = ~busy_ff;
      csr_ready  = 1'b1;
      top_bit    = pre[WordBits-1];
      ctrl.load  = seed_fire;
      ctrl.step  = tick_fire | (busy_ff & (~last_step | out_free));
   end

   // Increment enters at the low cell on the cycle a tick is taken
   assign carry[0] = tick_fire & incr_ff;

   // Chain of register cells
   for (genvar i = 0; i < WordBits; i++) begin : g_cell
      logic shift_bit;
      logic carry_nx;

      if (i == 0) begin : g_low
         assign shift_bit = 1'b0;
      end else begin : g_mid
         assign shift_bit = pre[i-1];
      end

      nwg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .reset_bit (SeedReset[i]),
         .load_bit  (req_tdata[i]),
         .carry_in  (carry[i]),
         .carry_out (carry_nx),
         .shift_in  (shift_bit),
         .tap       (top_bit & poly_ff[i]),
         .pre_bit   (pre[i])
      );

      if (i < WordBits - 1) begin : g_carry
         assign carry[i+1] = carry_nx;
      end
   end

   // Sequence the sixteen steps and collect the tested bits
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      word_in = word_ff;
      if (tick_fire) begin
         busy_in = 1'b1;
         cnt_in  = CountBits'(1);
         word_in = {word_ff[WordBits-2:0], top_bit};
      end else if (busy_ff & ~last_step) begin
         cnt_in  = cnt_ff + CountBits'(1);
         word_in = {word_ff[WordBits-2:0], top_bit};
      end else if (finish) begin
         busy_in = 1'b0;
         cnt_in  = '0;
      end
   end

   // Hold the finished word until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {word_ff[WordBits-2:0], top_bit};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         poly_ff      <= PolyReset;
         incr_ff      <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid & csr_ready) begin
            unique case (csr_index)
               CsrPoly: poly_ff <= csr_data;
               CsrIncr: incr_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A tick keeps the chain busy for the following steps
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> busy_ff)
      else $error("chain not busy after a tick");

   // A seed load never starts a run of steps
   a_seed_idle: assert property (@(posedge clock) disable iff (reset)
      seed_fire |=> !busy_ff)
      else $error("seed load started a run");

   // A new word only appears at the end of a run
   a_word_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(last_step))
      else $error("word appeared outside the end of a run");

   // The step count rests at zero while idle
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (cnt_ff == '0))
      else $error("step count not cleared while idle");

endmodule

// ===== bench/tb_lfsr_noise_word_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_lfsr_noise_word_generator_unit;
   import nwg_pkg::*;

   // One directed step: either a request item or a register write.
   // For items, known_word replaces the predicted word when has_known is set.
   typedef struct packed {
      logic                is_csr;
      logic                sel;         // request kind, or register index
      logic [WordBits-1:0] value;       // seed, or register data
      logic                has_known;
      logic [WordBits-1:0] known_word;
   } vector_row_type;

   localparam int NumRows = 26;
   localparam int NumPhases = 8;
   localparam int ItemsPerPhase = 200;
   localparam int SettleCycles = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [WordBits-1:0] req_tdata = '0;
   logic                req_tuser = ReqTick;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [WordBits-1:0] rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CsrPoly;
   logic [WordBits-1:0] csr_data = '0;

   // Predictor state and configuration copy
   logic [WordBits-1:0] lfsr_state = SeedReset;
   logic [WordBits-1:0] poly_cfg = PolyReset;
   logic                incr_cfg = 1'b0;

   logic [WordBits-1:0] noise_word_q[$];
   int                  mismatch_count = 0;
   logic                tx_idle = 1'b1;
   logic                rx_idle = 1'b1;
   vector_row_type      directed_rows [NumRows];

   lfsr_noise_word_generator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predict one accepted item: seed load or a full 16-step advance
   task automatic predict_noise(input logic kind, input logic [WordBits-1:0] seed,
                                input logic has_known, input logic [WordBits-1:0] known);
      logic [WordBits-1:0] lfsr;
      logic [WordBits-1:0] word;
      logic                top;
      int                  i;
      if (kind == ReqSeed) begin
         lfsr_state = seed;
      end else begin
         lfsr = lfsr_state + WordBits'(incr_cfg);
         word = '0;
         for (i = 0; i < WordBits; i++) begin
            top = lfsr[WordBits-1];
            word = {word[WordBits-2:0], top};
            lfsr = lfsr << 1;
            if (top) begin
               lfsr = lfsr ^ poly_cfg;
            end
         end
         lfsr_state = lfsr;
         noise_word_q.push_back(has_known ? known : word);
      end
   endtask

   // Send one request item after a random gap if tx_idle, then record its prediction
   task automatic send_request(input logic kind, input logic [WordBits-1:0] seed,
                               input logic has_known, input logic [WordBits-1:0] known);
      int gap;
      gap = tx_idle ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= seed;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predict_noise(kind, seed, has_known, known);
   endtask

   // Hold requests until every predicted word has come, then let the chain settle
   task automatic drain_words();
      req_tvalid <= 1'b0;
      while (noise_word_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write one configuration register and mirror it in the predictor
   task automatic write_csr(input logic idx, input logic [WordBits-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == CsrPoly) begin
         poly_cfg = data;
      end else begin
         incr_cfg = data[0];
      end
      @(posedge clock);
   endtask

   // Receive noise words with random stalls if rx_idle; compare with predictions
   initial begin
      int                  stall;
      logic [WordBits-1:0] want;
      wait (!reset);
      forever begin
         stall = rx_idle ? $urandom_range(0, 12) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         if (noise_word_q.size() == 0) begin
            $display("%0t ns: unexpected noise word, expected none, actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = noise_word_q.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t ns: noise word mismatch, expected %h, actual %h",
                        $time, want, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   // Main stimulus: directed rows, then random phases under varied settings
   initial begin
      int                  r;
      int                  p;
      int                  n;
      logic                kind;
      logic [WordBits-1:0] seed;
      logic [WordBits-1:0] poly;
      logic                incr;

      directed_rows = '{
         // tick right after reset: the single one bit reaches the top last
         '{1'b0, ReqTick, 16'h0000, 1'b1, 16'h0001},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         // all-zero register with increment off stays zero
         '{1'b0, ReqSeed, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b1, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b1, 16'h0000},
         '{1'b0, ReqSeed, 16'hFFFF, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqSeed, 16'h8000, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqSeed, 16'h0001, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b1, 16'h0001},
         // full polynomial with increment: all ones wraps to zero
         '{1'b1, CsrPoly, 16'hFFFF, 1'b0, 16'h0000},
         '{1'b1, CsrIncr, 16'h0001, 1'b0, 16'h0000},
         '{1'b0, ReqSeed, 16'hFFFF, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b1, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b1, 16'h0001},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         // empty polynomial: the register just shifts out
         '{1'b1, CsrPoly, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqSeed, 16'h1234, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         '{1'b1, CsrPoly, 16'h7FFF, 1'b0, 16'h0000},
         '{1'b1, CsrIncr, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqSeed, 16'hA5A5, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'h0000, 1'b0, 16'h0000},
         '{1'b0, ReqTick, 16'hFFFF, 1'b0, 16'h0000}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows; register writes only once the block is idle
      for (r = 0; r < NumRows; r++) begin
         if (directed_rows[r].is_csr) begin
            drain_words();
            write_csr(directed_rows[r].sel, directed_rows[r].value);
         end else begin
            send_request(directed_rows[r].sel, directed_rows[r].value,
                         directed_rows[r].has_known, directed_rows[r].known_word);
         end
      end

      // Random phases, each under its own setting and idling mix
      for (p = 0; p < NumPhases; p++) begin
         drain_words();
         case (p)
            0: begin poly = PolyReset; incr = 1'b0; end
            1: begin poly = 16'hFFFF; incr = 1'b1; end
            2: begin poly = 16'h0000; incr = 1'b0; end
            3: begin poly = 16'($urandom()) & 16'h7FFF; incr = 1'b1; end
            4: begin poly = 16'($urandom()); incr = 1'b0; end
            5: begin poly = 16'h8000; incr = 1'b1; end
            6: begin poly = 16'($urandom()); incr = 1'($urandom()); end
            default: begin poly = 16'h7FFF; incr = 1'b0; end
         endcase
         write_csr(CsrPoly, poly);
         write_csr(CsrIncr, {15'($urandom()), incr});
         tx_idle = (p % 4) != 1;
         rx_idle = (p % 4) != 2;
         for (n = 0; n < ItemsPerPhase; n++) begin
            kind = ($urandom_range(0, 4) == 0) ? ReqSeed : ReqTick;
            case ($urandom_range(0, 9))
               0: seed = 16'h0000;
               1: seed = 16'hFFFF;
               default: seed = 16'($urandom());
            endcase
            send_request(kind, seed, 1'b0, 16'h0000);
         end
      end

      drain_words();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
